/* hdl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, codes and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS_DEF  = 80;
    localparam int ROWS_DEF     = 25;
    localparam int TAB_STOP_DEF = 4;

    localparam int FUNC_W = 2;
    localparam int KIND_W = 3;
    localparam int CHAR_W = 8;
    localparam int TROW_W = 5;
    localparam int TCOL_W = 7;
    localparam int OCOL_W = 7;
    localparam int OROW_W = 5;
    localparam int OLIN_W = 11;
    localparam int CELL_W = 16;
    localparam int ATTR_W = 8;

    localparam int CMD_FIFO_DEPTH = 2;
    localparam int RES_FIFO_DEPTH = 2;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic REG_TEXT_ATTR  = 1'b0;
    localparam logic REG_CLEAR_ATTR = 1'b1;

    localparam logic [ATTR_W-1:0] TEXT_ATTR_RST  = 8'h0F;
    localparam logic [ATTR_W-1:0] CLEAR_ATTR_RST = 8'h07;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUT   = 2'd0,
        FN_READ  = 2'd1,
        FN_CLEAR = 2'd2,
        FN_SET   = 2'd3
    } t_func;

    typedef enum logic [KIND_W-1:0] {
        PK_CHAR      = 3'd0,
        PK_NEWLINE   = 3'd1,
        PK_BACKSPACE = 3'd2,
        PK_RETURN    = 3'd3,
        PK_TAB       = 3'd4
    } t_put_kind;

    typedef struct packed {
        logic [ATTR_W-1:0] text_attr;
        logic [ATTR_W-1:0] clear_attr;
    } t_attr;

    typedef struct packed {
        logic [OCOL_W-1:0] cursor_col;
        logic [OROW_W-1:0] cursor_row;
        logic [OLIN_W-1:0] cursor_linear;
        logic [CELL_W-1:0] cell_value;
    } t_result;

    localparam int RES_W = $bits(t_result);

    // width of the packed command word between front and back
    function automatic int cmd_width(input int cols, input int rows);
        return FUNC_W + KIND_W + CHAR_W + $clog2(rows) + $clog2(cols) + $clog2(rows * cols);
    endfunction

endpackage

/* hdl/tcw_fifo.sv */
// ----------------------------------------------------------------------------
// tcw_fifo
// Small register queue used between front and back and on the result side.
// ----------------------------------------------------------------------------
module tcw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    assign n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= n_wr;
            end
            if (w_pop) begin
                r_rd <= n_rd;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

/* hdl/tcw_front.sv */
// ----------------------------------------------------------------------------
// tcw_front
// Accepts input items, saturates targets, classifies control characters,
// precomputes the cell address and queues the command for the back end.
// ----------------------------------------------------------------------------
module tcw_front import tcw_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic [FUNC_W-1:0]                   i_func,
    input  logic [CHAR_W-1:0]                   i_char_code,
    input  logic [TROW_W-1:0]                   i_target_row,
    input  logic [TCOL_W-1:0]                   i_target_col,
    input  logic                                i_init_busy,
    output logic [cmd_width(COLUMNS, ROWS)-1:0] o_cmd,
    output logic                                o_cmd_valid,
    input  logic                                i_cmd_take
);

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(ROWS * COLUMNS);
    localparam int CMD_W  = cmd_width(COLUMNS, ROWS);

    typedef struct packed {
        t_func               func;
        t_put_kind           kind;
        logic [CHAR_W-1:0]   char_code;
        logic [ROW_W-1:0]    trow;
        logic [COL_W-1:0]    tcol;
        logic [ADDR_W-1:0]   addr;
    } t_cmd;

    t_cmd w_cmd;
    logic w_fifo_full;
    logic w_fifo_empty;

    always_comb begin
        w_cmd.func      = t_func'(i_func);
        w_cmd.char_code = i_char_code;
        unique case (i_char_code)
            CH_NEWLINE:   w_cmd.kind = PK_NEWLINE;
            CH_BACKSPACE: w_cmd.kind = PK_BACKSPACE;
            CH_RETURN:    w_cmd.kind = PK_RETURN;
            CH_TAB:       w_cmd.kind = PK_TAB;
            default:      w_cmd.kind = PK_CHAR;
        endcase
        if (int'(i_target_row) >= ROWS) begin
            w_cmd.trow = ROW_W'(ROWS - 1);
        end else begin
            w_cmd.trow = ROW_W'(i_target_row);
        end
        if (int'(i_target_col) >= COLUMNS) begin
            w_cmd.tcol = COL_W'(COLUMNS - 1);
        end else begin
            w_cmd.tcol = COL_W'(i_target_col);
        end
        w_cmd.addr = ADDR_W'(int'(w_cmd.trow) * COLUMNS + int'(w_cmd.tcol));
    end

    // no transfer while the screen is being cleared after reset
    assign o_full      = w_fifo_full || i_init_busy;
    assign o_cmd_valid = !w_fifo_empty;

    tcw_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_FIFO_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && !o_full),
        .i_data  (w_cmd),
        .o_full  (w_fifo_full),
        .i_pop   (i_cmd_take),
        .o_data  (o_cmd),
        .o_empty (w_fifo_empty)
    );

endmodule

/* hdl/tcw_back.sv */
// ----------------------------------------------------------------------------
// tcw_back
// Execution unit: owns the screen memory and the cursor, runs the fill and
// scroll sweeps and produces one result per command.
// ----------------------------------------------------------------------------
module tcw_back import tcw_pkg::*; #(
    parameter int COLUMNS  = COLUMNS_DEF,
    parameter int ROWS     = ROWS_DEF,
    parameter int TAB_STOP = TAB_STOP_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [cmd_width(COLUMNS, ROWS)-1:0] i_cmd,
    input  logic                                i_cmd_valid,
    output logic                                o_cmd_take,
    input  t_attr                               i_attr,
    input  logic                                i_res_full,
    output logic                                o_res_push,
    output t_result                             o_res,
    output logic                                o_init_busy
);

    localparam int CELLS         = ROWS * COLUMNS;
    localparam int COL_W         = $clog2(COLUMNS);
    localparam int ROW_W         = $clog2(ROWS);
    localparam int ADDR_W        = $clog2(CELLS);
    localparam int CNT_W         = $clog2(CELLS + 1);
    localparam int NCOL_W        = $clog2(COLUMNS + TAB_STOP);
    localparam int NROW_W        = $clog2(ROWS + 1);
    localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

    typedef struct packed {
        t_func               func;
        t_put_kind           kind;
        logic [CHAR_W-1:0]   char_code;
        logic [ROW_W-1:0]    trow;
        logic [COL_W-1:0]    tcol;
        logic [ADDR_W-1:0]   addr;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FILL = 4'b0010,
        S_COPY = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_cmd w_cmd;
    assign w_cmd = t_cmd'(i_cmd);

    logic [CELL_W-1:0] r_mem [CELLS];
    logic [CELL_W-1:0] r_rd_data;

    t_state            r_state, n_state;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic              r_init, n_init;
    logic [CNT_W-1:0]  r_addr, n_addr;
    logic [ADDR_W-1:0] r_waddr, n_waddr;
    logic              r_pend, n_pend;
    logic [ATTR_W-1:0] r_fill_attr, n_fill_attr;
    logic              r_is_read, n_is_read;

    logic              w_take;
    logic              w_copy_rd;
    logic [NCOL_W-1:0] w_tab_next [COLUMNS];
    logic [NCOL_W-1:0] w_put_col;
    logic [NROW_W-1:0] w_put_row;
    logic              w_scroll;
    logic [ADDR_W-1:0] w_cur_addr;

    logic              w_we;
    logic [ADDR_W-1:0] w_wa;
    logic [CELL_W-1:0] w_wd;
    logic              w_re;
    logic [ADDR_W-1:0] w_ra;

    // next tab stop for every column, built at elaboration
    for (genvar g = 0; g < COLUMNS; g++) begin : g_tab
        assign w_tab_next[g] = NCOL_W'(g + TAB_STOP - (g % TAB_STOP));
    end

    assign w_take      = (r_state == S_IDLE) && i_cmd_valid && !i_res_full;
    assign o_cmd_take  = w_take;
    assign o_init_busy = r_init;
    assign w_copy_rd   = (r_state == S_COPY) && (r_addr != CNT_W'(CELLS));
    assign w_cur_addr  = ADDR_W'(int'(r_row) * COLUMNS + int'(r_col));

    // cursor movement of a put, with wrap and scroll detection
    always_comb begin
        w_put_col = NCOL_W'(r_col);
        w_put_row = NROW_W'(r_row);
        unique case (w_cmd.kind)
            PK_NEWLINE: begin
                w_put_row = w_put_row + 1'b1;
                w_put_col = '0;
            end
            PK_BACKSPACE: begin
                if (r_col != '0) begin
                    w_put_col = w_put_col - 1'b1;
                end
            end
            PK_RETURN: w_put_col = '0;
            PK_TAB:    w_put_col = w_tab_next[r_col];
            default:   w_put_col = w_put_col + 1'b1;
        endcase
        if (w_put_col >= NCOL_W'(COLUMNS)) begin
            w_put_row = w_put_row + 1'b1;
            w_put_col = '0;
        end
        w_scroll = (w_put_row >= NROW_W'(ROWS));
        if (w_scroll) begin
            w_put_row = NROW_W'(ROWS - 1);
            w_put_col = '0;
        end
    end

    // memory port selection
    always_comb begin
        w_we = 1'b0;
        w_wa = w_cur_addr;
        w_wd = {i_attr.text_attr, w_cmd.char_code};
        w_re = 1'b0;
        w_ra = w_cmd.addr;
        unique case (r_state)
            S_IDLE: begin
                if (w_take && (w_cmd.func == FN_PUT)) begin
                    if (w_cmd.kind == PK_BACKSPACE) begin
                        w_we = (r_col != '0);
                        w_wa = w_cur_addr - 1'b1;
                        w_wd = {i_attr.text_attr, SPACE_CHAR};
                    end else if (w_cmd.kind == PK_CHAR) begin
                        w_we = 1'b1;
                    end
                end
                w_re = w_take && (w_cmd.func == FN_READ);
            end
            S_FILL: begin
                w_we = 1'b1;
                w_wa = r_addr[ADDR_W-1:0];
                w_wd = {r_fill_attr, SPACE_CHAR};
            end
            S_COPY: begin
                // read one row ahead, write the data back in the next cycle
                w_we = r_pend;
                w_wa = r_waddr;
                w_wd = r_rd_data;
                w_re = w_copy_rd;
                w_ra = r_addr[ADDR_W-1:0];
            end
            S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_ra];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_init      = r_init;
        n_addr      = r_addr;
        n_waddr     = r_waddr;
        n_pend      = r_pend;
        n_fill_attr = r_fill_attr;
        n_is_read   = r_is_read;
        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    n_is_read = (w_cmd.func == FN_READ);
                    unique case (w_cmd.func)
                        FN_PUT: begin
                            n_col = COL_W'(w_put_col);
                            n_row = ROW_W'(w_put_row);
                            if (w_scroll) begin
                                n_state = S_COPY;
                                n_addr  = CNT_W'(COLUMNS);
                                n_waddr = '0;
                                n_pend  = 1'b0;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        FN_READ: n_state = S_DONE;
                        FN_CLEAR: begin
                            n_col       = '0;
                            n_row       = '0;
                            n_addr      = '0;
                            n_fill_attr = i_attr.clear_attr;
                            n_state     = S_FILL;
                        end
                        FN_SET: begin
                            n_col   = w_cmd.tcol;
                            n_row   = w_cmd.trow;
                            n_state = S_DONE;
                        end
                        default: ;
                    endcase
                end
            end
            S_FILL: begin
                n_addr = r_addr + 1'b1;
                if (r_addr == CNT_W'(CELLS - 1)) begin
                    n_init  = 1'b0;
                    n_state = r_init ? S_IDLE : S_DONE;
                end
            end
            S_COPY: begin
                n_pend = w_copy_rd;
                if (w_copy_rd) begin
                    n_addr = r_addr + 1'b1;
                end
                if (r_pend) begin
                    n_waddr = r_waddr + 1'b1;
                end
                if (!w_copy_rd && r_pend) begin
                    // last row gets blanked with the text attribute
                    n_state     = S_FILL;
                    n_addr      = CNT_W'(LAST_ROW_BASE);
                    n_fill_attr = i_attr.text_attr;
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_init      <= 1'b1;
            r_addr      <= '0;
            r_waddr     <= '0;
            r_pend      <= 1'b0;
            r_fill_attr <= CLEAR_ATTR_RST;
            r_col       <= '0;
            r_row       <= '0;
            r_is_read   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_addr      <= n_addr;
            r_waddr     <= n_waddr;
            r_pend      <= n_pend;
            r_fill_attr <= n_fill_attr;
            r_col       <= n_col;
            r_row       <= n_row;
            r_is_read   <= n_is_read;
        end
    end

    assign o_res_push          = (r_state == S_DONE);
    assign o_res.cursor_col    = OCOL_W'(r_col);
    assign o_res.cursor_row    = OROW_W'(r_row);
    assign o_res.cursor_linear = OLIN_W'(int'(r_row) * COLUMNS + int'(r_col));
    assign o_res.cell_value    = r_is_read ? r_rd_data : '0;

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_col) < COLUMNS) && (int'(r_row) < ROWS))
        else $error("cursor out of screen");

    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result transfer into a full queue");

    a_no_take_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_take |-> !r_init)
        else $error("command taken during the clearing pass");

    a_copy_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY) && r_pend |-> int'(r_addr) == int'(r_waddr) + COLUMNS + 1)
        else $error("scroll copy read and write out of step");

endmodule

/* hdl/text_console_writer.sv */
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell text console with cursor, control characters and scroll.
// ----------------------------------------------------------------------------
// Commands enter through a two-entry queue and results leave through another,
// so push and pop may stall independently. Put character, read cell and set
// cursor go straight from idle to the done state in the execution unit. Clear
// screen and a put that scrolls sweep the single-write-port screen memory one
// cell a cycle. After reset a clearing pass fills the screen with blanks of
// attribute 0x07; full stays high meanwhile, while configuration writes are
// taken as usual. Register 0 at address 0 is the text attribute, register 1 at
// address 4 the clear attribute.
module text_console_writer import tcw_pkg::*; #(
    parameter int COLUMNS  = COLUMNS_DEF,
    parameter int ROWS     = ROWS_DEF,
    parameter int TAB_STOP = TAB_STOP_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [CHAR_W-1:0]  i_char_code,
    input  logic [TROW_W-1:0]  i_target_row,
    input  logic [TCOL_W-1:0]  i_target_col,
    output logic               empty,
    input  logic               pop,
    output logic [OCOL_W-1:0]  o_cursor_col,
    output logic [OROW_W-1:0]  o_cursor_row,
    output logic [OLIN_W-1:0]  o_cursor_linear,
    output logic [CELL_W-1:0]  o_cell_value,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int CMD_W = cmd_width(COLUMNS, ROWS);

    logic [ATTR_W-1:0] r_text_attr;
    logic [ATTR_W-1:0] r_clear_attr;
    t_attr             w_attr;
    logic              w_reg_idx;
    logic              w_cfg_wr;

    logic [CMD_W-1:0]  w_cmd;
    logic              w_cmd_valid;
    logic              w_cmd_take;
    logic              w_init_busy;
    logic              w_res_full;
    logic              w_res_push;
    t_result           w_res_in;
    t_result           w_res_out;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[PADDR_W-1];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_attr  <= TEXT_ATTR_RST;
            r_clear_attr <= CLEAR_ATTR_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_TEXT_ATTR:  r_text_attr  <= pwdata[ATTR_W-1:0];
                REG_CLEAR_ATTR: r_clear_attr <= pwdata[ATTR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_TEXT_ATTR:  prdata = PDATA_W'(r_text_attr);
            REG_CLEAR_ATTR: prdata = PDATA_W'(r_clear_attr);
            default:        prdata = '0;
        endcase
    end

    assign w_attr.text_attr  = r_text_attr;
    assign w_attr.clear_attr = r_clear_attr;

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_func       (i_func),
        .i_char_code  (i_char_code),
        .i_target_row (i_target_row),
        .i_target_col (i_target_col),
        .i_init_busy  (w_init_busy),
        .o_cmd        (w_cmd),
        .o_cmd_valid  (w_cmd_valid),
        .i_cmd_take   (w_cmd_take)
    );

    tcw_back #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_take  (w_cmd_take),
        .i_attr      (w_attr),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in),
        .o_init_busy (w_init_busy)
    );

    tcw_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_FIFO_DEPTH)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_out),
        .o_empty (empty)
    );

    assign o_cursor_col    = w_res_out.cursor_col;
    assign o_cursor_row    = w_res_out.cursor_row;
    assign o_cursor_linear = w_res_out.cursor_linear;
    assign o_cell_value    = w_res_out.cell_value;

endmodule
